>>> rtl/core/ppu_pkg.sv
// ----------------------------------------------------------------------------
// ppu_pkg
// Shared widths, register codes, reset values and the configuration bundle
// of the pinhole project / unproject unit.
// ----------------------------------------------------------------------------
package ppu_pkg;

   // field widths
   localparam int ROT_W      = 18;
   localparam int COORD_W    = 32;
   localparam int PIX_W      = 16;
   localparam int INTR_W     = 24;
   localparam int ROW_W      = 3 * ROT_W;

   // stream and register port widths
   localparam int REQ_DATA_W = 3 * COORD_W + 2 * PIX_W + COORD_W;
   localparam int RSP_DATA_W = 2 * PIX_W + 3 * COORD_W;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   // square root unit: one result bit per stage
   localparam int SQRT_STAGES = 31;
   localparam int SQRT_IN_W   = 2 * SQRT_STAGES;

   // divider: one quotient bit per stage
   localparam int DIV_STAGES = 32;
   localparam int DIV_Q_W    = DIV_STAGES;
   localparam int DIV_NUM_W  = 2 * DIV_Q_W;
   localparam int DIV_DEN_W  = 48;

   // command codes carried in tuser
   localparam logic CMD_PROJECT   = 1'b0;
   localparam logic CMD_UNPROJECT = 1'b1;

   // register map, one 64-bit slot per register
   typedef enum logic [2:0] {
      REG_ROT_ROW0,
      REG_ROT_ROW1,
      REG_ROT_ROW2,
      REG_TRANS_X,
      REG_TRANS_Y,
      REG_TRANS_Z,
      REG_FOCAL,
      REG_PRINCIPAL
   } reg_index_type;

   // reset values: identity rotation, unit focal length
   localparam logic [ROW_W-1:0]  RST_ROT_ROW0 = 54'h1_0000;
   localparam logic [ROW_W-1:0]  RST_ROT_ROW1 = 54'h1_0000 << ROT_W;
   localparam logic [ROW_W-1:0]  RST_ROT_ROW2 = 54'h1_0000 << (2 * ROT_W);
   localparam logic [INTR_W-1:0] RST_FOCAL    = 24'd256;

   // decoded configuration seen by the datapath
   typedef struct packed {
      logic [2:0][2:0][ROT_W-1:0] rot;    // [row][col], signed Q2.16
      logic [2:0][COORD_W-1:0]    trans;  // signed Q16.16
      logic [INTR_W-1:0]          focal;
      logic [INTR_W-1:0]          cx;
      logic [INTR_W-1:0]          cy;
   } cfg_type;

endpackage

>>> rtl/core/ppu_csr.sv
// ----------------------------------------------------------------------------
// ppu_csr
// Register file behind the APB-style port; decodes the rotation rows and
// principal point into the configuration bundle.
// ----------------------------------------------------------------------------
module ppu_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ppu_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [ppu_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [ppu_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   output ppu_pkg::cfg_type                cfg
);
   import ppu_pkg::*;

   logic [2:0][ROW_W-1:0]   rot_row_ff, rot_row_in;
   logic [2:0][COORD_W-1:0] trans_ff, trans_in;
   logic [INTR_W-1:0]       focal_ff, focal_in;
   logic [2*INTR_W-1:0]     pp_ff, pp_in;
   reg_index_type           idx;
   logic                    wr_en;

   assign csr_pready = 1'b1;
   assign idx        = reg_index_type'(csr_paddr[5:3]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // next register values on a completed write
   always_comb begin
      rot_row_in = rot_row_ff;
      trans_in   = trans_ff;
      focal_in   = focal_ff;
      pp_in      = pp_ff;
      if (wr_en) begin
         unique case (idx)
            REG_ROT_ROW0:  rot_row_in[0] = csr_pwdata[ROW_W-1:0];
            REG_ROT_ROW1:  rot_row_in[1] = csr_pwdata[ROW_W-1:0];
            REG_ROT_ROW2:  rot_row_in[2] = csr_pwdata[ROW_W-1:0];
            REG_TRANS_X:   trans_in[0]   = csr_pwdata[COORD_W-1:0];
            REG_TRANS_Y:   trans_in[1]   = csr_pwdata[COORD_W-1:0];
            REG_TRANS_Z:   trans_in[2]   = csr_pwdata[COORD_W-1:0];
            REG_FOCAL:     focal_in      = csr_pwdata[INTR_W-1:0];
            REG_PRINCIPAL: pp_in         = csr_pwdata[2*INTR_W-1:0];
            default:       focal_in      = focal_ff;
         endcase
      end
   end

   // hold the registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rot_row_ff[0] <= RST_ROT_ROW0;
         rot_row_ff[1] <= RST_ROT_ROW1;
         rot_row_ff[2] <= RST_ROT_ROW2;
         trans_ff      <= '0;
         focal_ff      <= RST_FOCAL;
         pp_ff         <= '0;
      end else begin
         rot_row_ff <= rot_row_in;
         trans_ff   <= trans_in;
         focal_ff   <= focal_in;
         pp_ff      <= pp_in;
      end
   end

   // read back
   always_comb begin
      unique case (idx)
         REG_ROT_ROW0:  csr_prdata = CSR_DATA_W'(rot_row_ff[0]);
         REG_ROT_ROW1:  csr_prdata = CSR_DATA_W'(rot_row_ff[1]);
         REG_ROT_ROW2:  csr_prdata = CSR_DATA_W'(rot_row_ff[2]);
         REG_TRANS_X:   csr_prdata = CSR_DATA_W'(trans_ff[0]);
         REG_TRANS_Y:   csr_prdata = CSR_DATA_W'(trans_ff[1]);
         REG_TRANS_Z:   csr_prdata = CSR_DATA_W'(trans_ff[2]);
         REG_FOCAL:     csr_prdata = CSR_DATA_W'(focal_ff);
         REG_PRINCIPAL: csr_prdata = CSR_DATA_W'(pp_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // unpack rows into entries, column 0 lowest
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            cfg.rot[i][j] = rot_row_ff[i][ROT_W*j +: ROT_W];
         end
      end
      cfg.trans = trans_ff;
      cfg.focal = focal_ff;
      cfg.cx    = pp_ff[INTR_W-1:0];
      cfg.cy    = pp_ff[2*INTR_W-1:INTR_W];
   end

endmodule

>>> rtl/core/ppu_isqrt.sv
// ----------------------------------------------------------------------------
// ppu_isqrt
// Pipelined integer square root, floor of the root, one result bit per
// stage; the whole line moves on advance.
// ----------------------------------------------------------------------------
module ppu_isqrt (
   input  logic                           clock,
   input  logic                           advance,
   input  logic [ppu_pkg::SQRT_IN_W-1:0]  radicand,
   output logic [ppu_pkg::SQRT_STAGES-1:0] root
);
   import ppu_pkg::*;

   localparam int REM_W = SQRT_STAGES + 2;

   logic [REM_W-1:0]       rem_ff  [SQRT_STAGES];
   logic [SQRT_STAGES-1:0] root_ff [SQRT_STAGES];
   logic [SQRT_IN_W-1:0]   x_ff    [SQRT_STAGES];

   for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
      logic [REM_W-1:0]       rem_prev, rem_in;
      logic [SQRT_STAGES-1:0] root_prev, root_in;
      logic [SQRT_IN_W-1:0]   x_prev;
      logic [REM_W+1:0]       rem_sh, trial;

      if (s == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign x_prev    = radicand;
      end else begin : g_next
         assign rem_prev  = rem_ff[s-1];
         assign root_prev = root_ff[s-1];
         assign x_prev    = x_ff[s-1];
      end

      // bring down the next bit pair and try the next root bit
      always_comb begin
         rem_sh = {rem_prev, x_prev[2*(SQRT_STAGES-1-s)+1 -: 2]};
         trial  = {2'b00, root_prev, 2'b01};
         if (rem_sh >= trial) begin
            rem_in  = REM_W'(rem_sh - trial);
            root_in = {root_prev[SQRT_STAGES-2:0], 1'b1};
         end else begin
            rem_in  = REM_W'(rem_sh);
            root_in = {root_prev[SQRT_STAGES-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
            x_ff[s]    <= x_prev;
         end
      end
   end

   assign root = root_ff[SQRT_STAGES-1];

endmodule

>>> rtl/core/ppu_divider.sv
// ----------------------------------------------------------------------------
// ppu_divider
// Pipelined unsigned restoring divider, one quotient bit per stage. The
// upper half of the numerator must be below the divisor.
// ----------------------------------------------------------------------------
module ppu_divider (
   input  logic                           clock,
   input  logic                           advance,
   input  logic [ppu_pkg::DIV_NUM_W-1:0]  num,
   input  logic [ppu_pkg::DIV_DEN_W-1:0]  den,
   output logic [ppu_pkg::DIV_Q_W-1:0]    quot
);
   import ppu_pkg::*;

   localparam int P_W = DIV_DEN_W + 1;

   logic [P_W-1:0]       p_ff   [DIV_STAGES];
   logic [DIV_DEN_W-1:0] den_ff [DIV_STAGES];
   logic [DIV_Q_W-1:0]   nlo_ff [DIV_STAGES];
   logic [DIV_Q_W-1:0]   q_ff   [DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      logic [P_W-1:0]       p_prev, p_in, sh;
      logic [DIV_DEN_W-1:0] den_prev;
      logic [DIV_Q_W-1:0]   nlo_prev, q_prev, q_in;

      if (s == 0) begin : g_first
         assign p_prev   = P_W'(num[DIV_NUM_W-1:DIV_Q_W]);
         assign den_prev = den;
         assign nlo_prev = num[DIV_Q_W-1:0];
         assign q_prev   = '0;
      end else begin : g_next
         assign p_prev   = p_ff[s-1];
         assign den_prev = den_ff[s-1];
         assign nlo_prev = nlo_ff[s-1];
         assign q_prev   = q_ff[s-1];
      end

      // shift in the next numerator bit and subtract where it fits
      always_comb begin
         sh = {p_prev[P_W-2:0], nlo_prev[DIV_Q_W-1-s]};
         if (sh >= {1'b0, den_prev}) begin
            p_in = sh - {1'b0, den_prev};
            q_in = {q_prev[DIV_Q_W-2:0], 1'b1};
         end else begin
            p_in = sh;
            q_in = {q_prev[DIV_Q_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            p_ff[s]   <= p_in;
            den_ff[s] <= den_prev;
            nlo_ff[s] <= nlo_prev;
            q_ff[s]   <= q_in;
         end
      end
   end

   assign quot = q_ff[DIV_STAGES-1];

endmodule

>>> rtl/core/pinhole_project_unproject_unit.sv
// ----------------------------------------------------------------------------
// pinhole_project_unproject_unit
// Pinhole camera projection of world points and unprojection of pixels with
// depth, fully pipelined.
// ----------------------------------------------------------------------------
// The unit takes one beat per cycle and returns one result beat per input
// beat, in order, through five stages of set-up arithmetic, the 31-stage
// square root pipeline, three 32-stage divider pipelines shared by both
// commands, and three stages of rotation, saturation and output
// register. All stages advance together; the pipeline holds only while the
// output register carries a beat that has not been taken. Configuration is
// read directly by the datapath and must be written while the unit is idle.
// ----------------------------------------------------------------------------
module pinhole_project_unproject_unit (
   input  logic                            clock,
   input  logic                            reset,
   // input stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // world_x, world_y, world_z, pix_u, pix_v, ray_depth (from bit 0 up)
   input  logic [ppu_pkg::REQ_DATA_W-1:0]  req_tdata,
   // cmd
   input  logic                            req_tuser,
   // result stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // out_u, out_v, out_x, out_y, out_z (from bit 0 up)
   output logic [ppu_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // valid_res
   output logic                            rsp_tuser,
   // configuration port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ppu_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [ppu_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [ppu_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import ppu_pkg::*;

   typedef struct packed {
      logic              valid;
      logic              cmd;
      logic              fzero;
      logic [2:0][32:0]  diff;
      logic [1:0][25:0]  d;
      logic [31:0]       depth;
   } s1_type;

   typedef struct packed {
      logic                  valid;
      logic                  cmd;
      logic                  fzero;
      logic [2:0][2:0][50:0] prod;
      logic [2:0][51:0]      sq;
      logic [2:0][56:0]      magdep;
      logic [2:0]            dneg;
   } s2_type;

   typedef struct packed {
      logic              valid;
      logic              cmd;
      logic              fzero;
      logic [2:0][36:0]  p;
      logic [61:0]       xs;
      logic [2:0][56:0]  magdep;
      logic [2:0]        dneg;
   } s3_type;

   typedef struct packed {
      logic              valid;
      logic              cmd;
      logic              fzero;
      logic              pz_zero;
      logic              pz_neg;
      logic [62:0]       fu;
      logic [62:0]       cup;
      logic [62:0]       fv;
      logic [62:0]       cvp;
      logic [44:0]       denmag;
      logic [61:0]       xs;
      logic [2:0][56:0]  magdep;
      logic [2:0]        dneg;
   } s4_type;

   typedef struct packed {
      logic              valid;
      logic              cmd;
      logic              bad;
      logic [1:0][63:0]  nmag;
      logic [1:0]        nneg;
      logic [44:0]       denmag;
      logic [2:0][56:0]  magdep;
      logic [2:0]        dneg;
   } mid_type;

   typedef struct packed {
      logic       valid;
      logic       cmd;
      logic       bad;
      logic [1:0] ovf;
      logic [2:0] qneg;
   } side_type;

   typedef struct packed {
      logic              valid;
      logic              cmd;
      logic              bad;
      logic              sat;
      logic [15:0]       u;
      logic [15:0]       v;
      logic [2:0][32:0]  cam;
   } s7_type;

   typedef struct packed {
      logic                  valid;
      logic                  cmd;
      logic                  bad;
      logic                  sat;
      logic [15:0]           u;
      logic [15:0]           v;
      logic [2:0][2:0][50:0] wprod;
   } s8_type;

   cfg_type  cfg;
   logic     advance;
   s1_type   s1_ff, s1_in;
   s2_type   s2_ff, s2_in;
   s3_type   s3_ff, s3_in;
   s4_type   s4_ff, s4_in;
   mid_type  s5_ff, s5_in;
   logic [SQRT_IN_W-1:0]   s5_xs_ff;
   mid_type  mid_ff [SQRT_STAGES];
   mid_type  mid_last;
   logic [SQRT_STAGES-1:0] sqrt_root;
   side_type side_in;
   side_type side_ff [DIV_STAGES];
   side_type side_last;
   logic [DIV_NUM_W-1:0]   div_num  [3];
   logic [DIV_DEN_W-1:0]   div_den  [3];
   logic [DIV_Q_W-1:0]     div_quot [3];
   s7_type   s7_ff, s7_in;
   s8_type   s8_ff, s8_in;
   logic                   rsp_valid_ff;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                   rsp_user_ff, rsp_user_in;

   ppu_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // the pipeline moves unless the output beat is held
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   // stage 1: offset from camera, ray in Q.8
   always_comb begin
      logic [31:0] wv;
      s1_in.valid = req_tvalid && req_tready;
      s1_in.cmd   = req_tuser;
      for (int j = 0; j < 3; j++) begin
         wv = req_tdata[32*j +: 32];
         s1_in.diff[j] = {wv[31], wv} - {cfg.trans[j][31], cfg.trans[j]};
      end
      s1_in.d[0]  = {{2{req_tdata[111]}}, req_tdata[111:96], 8'd0} - {2'b00, cfg.cx};
      s1_in.d[1]  = {{2{req_tdata[127]}}, req_tdata[127:112], 8'd0} - {2'b00, cfg.cy};
      s1_in.depth = req_tdata[159:128];
      s1_in.fzero = (cfg.focal == '0);
   end

   // stage 2: rotation products, squares, magnitude times depth
   always_comb begin
      logic signed [50:0] ra, da;
      logic signed [25:0] dv;
      logic signed [51:0] dd;
      logic [24:0]        mag;
      s2_in.valid = s1_ff.valid;
      s2_in.cmd   = s1_ff.cmd;
      s2_in.fzero = s1_ff.fzero;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            ra = $signed(cfg.rot[i][j]);
            da = $signed(s1_ff.diff[j]);
            s2_in.prod[i][j] = ra * da;
         end
      end
      for (int i = 0; i < 2; i++) begin
         dv  = $signed(s1_ff.d[i]);
         dd  = dv;
         mag = dv[25] ? 25'(-dv) : 25'(dv);
         s2_in.sq[i]     = dd * dd;
         s2_in.dneg[i]   = dv[25];
         s2_in.magdep[i] = 57'(mag) * 57'(s1_ff.depth);
      end
      s2_in.sq[2]     = 52'(cfg.focal) * 52'(cfg.focal);
      s2_in.dneg[2]   = 1'b0;
      s2_in.magdep[2] = 57'(cfg.focal) * 57'(s1_ff.depth);
   end

   // stage 3: camera point floored to Q.16, scaled squared norm
   always_comb begin
      logic signed [52:0] acc;
      logic [61:0]        ssum;
      s3_in.valid  = s2_ff.valid;
      s3_in.cmd    = s2_ff.cmd;
      s3_in.fzero  = s2_ff.fzero;
      for (int i = 0; i < 3; i++) begin
         acc = $signed(s2_ff.prod[i][0]) + $signed(s2_ff.prod[i][1])
             + $signed(s2_ff.prod[i][2]);
         s3_in.p[i] = acc[52:16];
      end
      ssum = 62'(s2_ff.sq[0]) + 62'(s2_ff.sq[1]) + 62'(s2_ff.sq[2]);
      s3_in.xs     = ssum << 10;
      s3_in.magdep = s2_ff.magdep;
      s3_in.dneg   = s2_ff.dneg;
   end

   // stage 4: numerator products, divisor magnitude
   always_comb begin
      logic signed [62:0] fe, cxe, cye, p0, p1, p2;
      logic [36:0]        pabs;
      fe  = $signed({39'd0, cfg.focal});
      cxe = $signed({39'd0, cfg.cx});
      cye = $signed({39'd0, cfg.cy});
      p0  = $signed(s3_ff.p[0]);
      p1  = $signed(s3_ff.p[1]);
      p2  = $signed(s3_ff.p[2]);
      pabs = s3_ff.p[2][36] ? 37'(-s3_ff.p[2]) : s3_ff.p[2];
      s4_in.valid   = s3_ff.valid;
      s4_in.cmd     = s3_ff.cmd;
      s4_in.fzero   = s3_ff.fzero;
      s4_in.pz_zero = (s3_ff.p[2] == '0);
      s4_in.pz_neg  = s3_ff.p[2][36];
      s4_in.fu      = fe * p0;
      s4_in.cup     = cxe * p2;
      s4_in.fv      = fe * p1;
      s4_in.cvp     = cye * p2;
      s4_in.denmag  = {pabs, 8'd0};
      s4_in.xs      = s3_ff.xs;
      s4_in.magdep  = s3_ff.magdep;
      s4_in.dneg    = s3_ff.dneg;
   end

   // stage 5: pixel numerators as sign and magnitude
   always_comb begin
      logic signed [62:0] nu, nv;
      nu = $signed(s4_ff.fu) + $signed(s4_ff.cup);
      nv = $signed(s4_ff.fv) + $signed(s4_ff.cvp);
      s5_in.valid   = s4_ff.valid;
      s5_in.cmd     = s4_ff.cmd;
      s5_in.bad     = (s4_ff.cmd == CMD_PROJECT) ? s4_ff.pz_zero : s4_ff.fzero;
      s5_in.nmag[0] = 64'(nu[62] ? 63'(-nu) : 63'(nu));
      s5_in.nmag[1] = 64'(nv[62] ? 63'(-nv) : 63'(nv));
      s5_in.nneg[0] = nu[62] ^ s4_ff.pz_neg;
      s5_in.nneg[1] = nv[62] ^ s4_ff.pz_neg;
      s5_in.denmag  = s4_ff.denmag;
      s5_in.magdep  = s4_ff.magdep;
      s5_in.dneg    = s4_ff.dneg;
   end

   // advance the front stages
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
         s4_ff.valid <= 1'b0;
         s5_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_ff    <= s1_in;
         s2_ff    <= s2_in;
         s3_ff    <= s3_in;
         s4_ff    <= s4_in;
         s5_ff    <= s5_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s5_xs_ff <= s4_ff.xs;
      end
   end

   // ray length, with the rest of the item alongside
   ppu_isqrt u_isqrt (
      .clock    (clock),
      .advance  (advance),
      .radicand (s5_xs_ff),
      .root     (sqrt_root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SQRT_STAGES; k++) begin
            mid_ff[k].valid <= 1'b0;
         end
      end else if (advance) begin
         mid_ff[0] <= s5_ff;
         for (int k = 1; k < SQRT_STAGES; k++) begin
            mid_ff[k] <= mid_ff[k-1];
         end
      end
   end

   assign mid_last = mid_ff[SQRT_STAGES-1];

   // divider operands: pixel quotients or ray components
   always_comb begin
      logic [DIV_DEN_W-1:0] pden;
      pden = mid_last.bad ? DIV_DEN_W'(1) : DIV_DEN_W'(mid_last.denmag);
      side_in.valid = mid_last.valid;
      side_in.cmd   = mid_last.cmd;
      side_in.bad   = mid_last.bad;
      side_in.ovf   = '0;
      if (mid_last.cmd == CMD_PROJECT) begin
         for (int k = 0; k < 2; k++) begin
            div_num[k]     = mid_last.nmag[k];
            div_den[k]     = pden;
            side_in.ovf[k] = (DIV_DEN_W'(mid_last.nmag[k][DIV_NUM_W-1:DIV_Q_W]) >= pden);
         end
         div_num[2]   = '0;
         div_den[2]   = DIV_DEN_W'(1);
         side_in.qneg = {1'b0, mid_last.nneg};
      end else begin
         for (int k = 0; k < 3; k++) begin
            div_num[k] = DIV_NUM_W'({mid_last.magdep[k], 5'd0});
            div_den[k] = (sqrt_root == '0) ? DIV_DEN_W'(1) : DIV_DEN_W'(sqrt_root);
         end
         side_in.qneg = mid_last.dneg;
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_div
      ppu_divider u_divider (
         .clock   (clock),
         .advance (advance),
         .num     (div_num[k]),
         .den     (div_den[k]),
         .quot    (div_quot[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            side_ff[k].valid <= 1'b0;
         end
      end else if (advance) begin
         side_ff[0] <= side_in;
         for (int k = 1; k < DIV_STAGES; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign side_last = side_ff[DIV_STAGES-1];

   // stage 7: apply signs, saturate pixels
   always_comb begin
      logic [1:0][15:0] uv;
      logic             sat;
      logic [31:0]      q;
      sat = 1'b0;
      for (int k = 0; k < 2; k++) begin
         q = div_quot[k];
         if (side_last.qneg[k]) begin
            if (side_last.ovf[k] || q > 32'd32768) begin
               uv[k] = 16'h8000;
               sat   = 1'b1;
            end else begin
               uv[k] = 16'(32'd0 - q);
            end
         end else begin
            if (side_last.ovf[k] || q > 32'd32767) begin
               uv[k] = 16'h7FFF;
               sat   = 1'b1;
            end else begin
               uv[k] = 16'(q);
            end
         end
      end
      for (int k = 0; k < 3; k++) begin
         s7_in.cam[k] = side_last.qneg[k] ? 33'd0 - {1'b0, div_quot[k]}
                                          : {1'b0, div_quot[k]};
      end
      s7_in.valid = side_last.valid;
      s7_in.cmd   = side_last.cmd;
      s7_in.bad   = side_last.bad;
      s7_in.sat   = sat;
      s7_in.u     = uv[0];
      s7_in.v     = uv[1];
   end

   // stage 8: back-rotation products, transpose of the matrix
   always_comb begin
      logic signed [50:0] ra, ca;
      s8_in.valid = s7_ff.valid;
      s8_in.cmd   = s7_ff.cmd;
      s8_in.bad   = s7_ff.bad;
      s8_in.sat   = s7_ff.sat;
      s8_in.u     = s7_ff.u;
      s8_in.v     = s7_ff.v;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            ra = $signed(cfg.rot[i][j]);
            ca = $signed(s7_ff.cam[i]);
            s8_in.wprod[i][j] = ra * ca;
         end
      end
   end

   // output stage: world sums, clamp, pack the beat
   always_comb begin
      logic signed [52:0] acc;
      logic signed [36:0] fl;
      logic signed [37:0] w;
      logic [2:0][31:0]   wc;
      logic               wsat;
      wsat = 1'b0;
      for (int j = 0; j < 3; j++) begin
         acc = $signed(s8_ff.wprod[0][j]) + $signed(s8_ff.wprod[1][j])
             + $signed(s8_ff.wprod[2][j]);
         fl  = acc[52:16];
         w   = fl + $signed(cfg.trans[j]);
         if (w > 38'sd2147483647) begin
            wc[j] = 32'h7FFF_FFFF;
            wsat  = 1'b1;
         end else if (w < -38'sd2147483648) begin
            wc[j] = 32'h8000_0000;
            wsat  = 1'b1;
         end else begin
            wc[j] = w[31:0];
         end
      end
      if (s8_ff.bad) begin
         rsp_data_in = '0;
         rsp_user_in = 1'b0;
      end else if (s8_ff.cmd == CMD_PROJECT) begin
         rsp_data_in = {96'd0, s8_ff.v, s8_ff.u};
         rsp_user_in = !s8_ff.sat;
      end else begin
         rsp_data_in = {wc[2], wc[1], wc[0], 32'd0};
         rsp_user_in = !wsat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_ff.valid  <= 1'b0;
         s8_ff.valid  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s7_ff        <= s7_in;
         s8_ff        <= s8_in;
         rsp_valid_ff <= s8_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // an accepted beat enters the first stage
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> s1_ff.valid)
      else $error("accepted beat missing from first stage");

   // a stall keeps the item in the first stage
   a_stall_keeps: assert property (@(posedge clock) disable iff (reset)
      s1_ff.valid && !advance |=> s1_ff.valid)
      else $error("item lost during stall");

   // a ray with non-zero focal length has a non-zero length
   a_root_nonzero: assert property (@(posedge clock) disable iff (reset)
      mid_last.valid && mid_last.cmd == CMD_UNPROJECT && !mid_last.bad
      |-> sqrt_root != '0)
      else $error("zero ray length with valid focal length");

endmodule

>>> sim/ppu_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ppu_checker
// Watches the request, result and register ports of the pinhole unit. It
// keeps its own copy of the camera set-up, works out the pixel or world point
// that each accepted request must give, and compares the result beats in
// order, field by field.
// ----------------------------------------------------------------------------
module ppu_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [ppu_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [ppu_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            rsp_tuser,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ppu_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [ppu_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   input  logic                            csr_pready,
   output int                              errors,
   output int                              pending,
   output int                              n_project,
   output int                              n_unproject,
   output int                              n_good
);
   import ppu_pkg::*;

   typedef struct {
      logic [15:0] u;
      logic [15:0] v;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic        good;
   } camera_result_type;

   // camera set-up as last written
   logic [ROW_W-1:0]   rot_row [3];
   logic [COORD_W-1:0] cam_pos [3];
   logic [INTR_W-1:0]  focal_len;
   logic [47:0]        centre;

   camera_result_type expected_results [$];

   function automatic longint rot_at(int row, int col);
      return longint'($signed(rot_row[row][col*ROT_W +: ROT_W]));
   endfunction

   // largest r with r*r <= x, built one bit at a time from the top
   function automatic longint unsigned root_floor(longint unsigned x);
      longint unsigned r;
      longint unsigned cand;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         cand = r | (64'd1 << b);
         if (cand * cand <= x) r = cand;
      end
      return r;
   endfunction

   function automatic longint clip(longint x, longint lo, longint hi, ref logic good);
      if (x < lo) begin
         good = 1'b0;
         return lo;
      end
      if (x > hi) begin
         good = 1'b0;
         return hi;
      end
      return x;
   endfunction

   function automatic camera_result_type predict_camera(logic cmd,
         logic [REQ_DATA_W-1:0] d);
      camera_result_type r;
      longint t [3];
      longint cam [3];
      longint ray [3];
      longint f, cx, cy, acc, nu, nv, den;
      longint unsigned sq, len, mag, q, depth;
      r = '{16'd0, 16'd0, 32'd0, 32'd0, 32'd0, 1'b1};
      for (int j = 0; j < 3; j++) t[j] = longint'($signed(cam_pos[j]));
      f  = longint'(focal_len);
      cx = longint'(centre[23:0]);
      cy = longint'(centre[47:24]);
      if (cmd == CMD_PROJECT) begin
         // move into the camera frame, floor to Q.16
         for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++)
               acc += rot_at(i, j) * (longint'($signed(d[32*j +: 32])) - t[j]);
            cam[i] = acc >>> 16;
         end
         if (cam[2] == 0) begin
            r.good = 1'b0;
            return r;
         end
         nu  = f * cam[0] + cx * cam[2];
         nv  = f * cam[1] + cy * cam[2];
         den = cam[2] * 256;
         r.u = 16'(clip(nu / den, -32768, 32767, r.good));
         r.v = 16'(clip(nv / den, -32768, 32767, r.good));
      end else begin
         if (f == 0) begin
            r.good = 1'b0;
            return r;
         end
         depth  = longint'(d[159:128]);
         ray[0] = longint'($signed(d[111:96])) * 256 - cx;
         ray[1] = longint'($signed(d[127:112])) * 256 - cy;
         ray[2] = f;
         sq = 0;
         for (int i = 0; i < 3; i++) sq += longint'(ray[i] * ray[i]);
         len = root_floor(sq << 10);
         for (int i = 0; i < 3; i++) begin
            mag    = (ray[i] < 0) ? -ray[i] : ray[i];
            q      = (mag * depth * 32) / len;
            cam[i] = (ray[i] < 0) ? -longint'(q) : longint'(q);
         end
         // rotate back into the world frame and add the camera position
         for (int j = 0; j < 3; j++) begin
            acc = 0;
            for (int i = 0; i < 3; i++) acc += rot_at(i, j) * cam[i];
            acc = clip((acc >>> 16) + t[j], -64'sd2147483648, 64'sd2147483647, r.good);
            case (j)
               0: r.x = 32'(acc);
               1: r.y = 32'(acc);
               default: r.z = 32'(acc);
            endcase
         end
      end
      return r;
   endfunction

   task automatic report(string what, logic [31:0] want, logic [31:0] got);
      errors++;
      if (errors <= 10)
         $display("%0t mismatch on %s: expected %h, got %h", $realtime, what, want, got);
   endtask

   always @(posedge clock) begin
      camera_result_type want;
      if (reset) begin
         rot_row[0]  = RST_ROT_ROW0;
         rot_row[1]  = RST_ROT_ROW1;
         rot_row[2]  = RST_ROT_ROW2;
         cam_pos     = '{32'd0, 32'd0, 32'd0};
         focal_len   = RST_FOCAL;
         centre      = 48'd0;
         expected_results.delete();
         errors = 0; n_project = 0; n_unproject = 0; n_good = 0;
      end else begin
         // track register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[5:3]))
               REG_ROT_ROW0: rot_row[0] = csr_pwdata[ROW_W-1:0];
               REG_ROT_ROW1: rot_row[1] = csr_pwdata[ROW_W-1:0];
               REG_ROT_ROW2: rot_row[2] = csr_pwdata[ROW_W-1:0];
               REG_TRANS_X:  cam_pos[0] = csr_pwdata[31:0];
               REG_TRANS_Y:  cam_pos[1] = csr_pwdata[31:0];
               REG_TRANS_Z:  cam_pos[2] = csr_pwdata[31:0];
               REG_FOCAL:    focal_len  = csr_pwdata[INTR_W-1:0];
               REG_PRINCIPAL: centre    = csr_pwdata[47:0];
               default: ;
            endcase
         end
         // check the result beat against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               errors++;
               if (errors <= 10) $display("%0t result beat with nothing expected", $realtime);
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata[15:0] !== want.u)   report("out_u", want.u, rsp_tdata[15:0]);
               if (rsp_tdata[31:16] !== want.v)  report("out_v", want.v, rsp_tdata[31:16]);
               if (rsp_tdata[63:32] !== want.x)  report("out_x", want.x, rsp_tdata[63:32]);
               if (rsp_tdata[95:64] !== want.y)  report("out_y", want.y, rsp_tdata[95:64]);
               if (rsp_tdata[127:96] !== want.z) report("out_z", want.z, rsp_tdata[127:96]);
               if (rsp_tuser !== want.good)      report("valid_res", want.good, rsp_tuser);
               if (want.good) n_good++;
            end
         end
         // predict each accepted request
         if (req_tvalid && req_tready) begin
            expected_results.push_back(predict_camera(req_tuser, req_tdata));
            if (req_tuser == CMD_PROJECT) n_project++;
            else n_unproject++;
         end
      end
      pending = expected_results.size();
   end

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the pinhole unit with projection and unprojection requests under
// several camera set-ups, with random gaps and stalls on both streams, and
// gives the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module tb;
   import ppu_pkg::*;

   localparam int IDLE_LIMIT  = 20000;
   localparam int PHASES      = 8;
   localparam int PHASE_BEATS = 200;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid, req_tready, req_tuser;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid, rsp_tready, rsp_tuser;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata, csr_prdata;

   int errors, pending, n_project, n_unproject, n_good;
   int idle_cycles;
   int phase;
   int rsp_beats;
   bit sender_busy;

   pinhole_project_unproject_unit dut (.*);

   ppu_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // stop the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic logic [REQ_DATA_W-1:0] pack_req(logic [31:0] wx, logic [31:0] wy,
         logic [31:0] wz, logic [15:0] pu, logic [15:0] pv, logic [31:0] depth);
      return {depth, pv, pu, wz, wy, wx};
   endfunction

   task automatic csr_write(reg_index_type idx, logic [63:0] value);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = CSR_ADDR_W'({idx, 3'b000});
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   // hold the sender until every result has come back, then let the pipe empty
   task automatic drain;
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic send_beat(logic cmd, logic [REQ_DATA_W-1:0] data);
      int gap;
      gap = sender_busy ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser  = cmd;
      req_tdata  = data;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic load_camera(int p);
      logic [63:0] v [8];
      case (p)
         1: v = '{RST_ROT_ROW0, RST_ROT_ROW1, RST_ROT_ROW2, 64'h0001_8000,
                  64'hFFFE_0000, 64'hFFF0_0000, 64'd128000, {16'd0, 24'd61440, 24'd81920}};
         3: v = '{{54{1'b1}}, {54{1'b1}}, {54{1'b1}}, 64'h7FFF_FFFF,
                  64'h7FFF_FFFF, 64'h7FFF_FFFF, 64'hFF_FFFF, {48{1'b1}}};
         4: v = '{{3{18'h20000}}, {3{18'h20000}}, {3{18'h20000}}, 64'h8000_0000,
                  64'h8000_0000, 64'h8000_0000, 64'd1, 64'd0};
         5: v = '{RST_ROT_ROW0, RST_ROT_ROW1, RST_ROT_ROW2, 64'h0002_0000,
                  64'h0, 64'hFFFF_0000, 64'd0, {16'd0, 24'd25600, 24'd51200}};
         7: v = '{{18'd0, 18'h30000, 18'd0}, {36'd0, 18'h10000}, {18'h10000, 36'd0},
                  64'h0000_4000, 64'h0003_0000, 64'hFFFF_C000, 64'd76800,
                  {16'd0, 24'd40960, 24'd40960}};
         default: begin
            for (int i = 0; i < 3; i++)
               v[i] = {$urandom, $urandom} & {10'd0, {54{1'b1}}};
            for (int i = 3; i < 6; i++) v[i] = $urandom;
            v[6] = $urandom_range(1, 24'hFF_FFFF);
            v[7] = {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF;
         end
      endcase
      for (int i = 0; i < 8; i++) csr_write(reg_index_type'(i), v[i]);
   endtask

   // mostly plausible points and pixels, some full-range noise
   task automatic send_random;
      int kind;
      logic [31:0] wx, wy, wz, depth;
      logic [15:0] pu, pv;
      kind = $urandom_range(0, 9);
      wx = $urandom; wy = $urandom; wz = $urandom;
      pu = $urandom; pv = $urandom; depth = $urandom;
      if (kind >= 2) begin
         wx = 32'($signed(int'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000));
         wy = 32'($signed(int'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000));
         wz = $urandom_range(32'h0000_8000, 32'h0400_0000);
         pu = 16'($urandom_range(0, 4095) - 2048);
         pv = 16'($urandom_range(0, 4095) - 2048);
         depth = $urandom_range(0, 32'h0100_0000);
      end
      send_beat((kind % 2 == 0) ? CMD_PROJECT : CMD_UNPROJECT,
                pack_req(wx, wy, wz, pu, pv, depth));
   endtask

   // receiver: random stalls, one long hold-off to fill the pipeline
   initial begin
      int stall;
      rsp_tready = 1'b0;
      rsp_beats  = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = ((rsp_beats / 150) % 3 == 1) ? 0 : $urandom_range(0, 19);
         if (rsp_beats == 250) stall = 1000;
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         rsp_beats++;
         @(negedge clock);
      end
   end

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tuser   = CMD_PROJECT;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      sender_busy = 1'b0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // directed beats under the reset set-up: identity, origin, unit focus
      send_beat(CMD_PROJECT, pack_req(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 32'h0));
      send_beat(CMD_PROJECT, pack_req(32'h1_0000, 32'h2_0000, 32'h4_0000, 16'h0, 16'h0, 32'h0));
      send_beat(CMD_PROJECT, pack_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1_0000, 16'h0, 16'h0, 0));
      send_beat(CMD_PROJECT, pack_req(32'h7FFF_FFFF, 32'h0, 32'h1, 16'h0, 16'h0, 32'h0));
      send_beat(CMD_PROJECT, pack_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                      16'h0, 16'h0, 32'h0));
      send_beat(CMD_PROJECT, pack_req(32'h1_0000, 32'h1_0000, 32'hFFFF_0000, 16'h0, 16'h0, 0));
      send_beat(CMD_PROJECT, pack_req(32'h8000_0000, 32'h0, 32'h1_0000, 16'h0, 16'h0, 32'h0));
      send_beat(CMD_PROJECT, {REQ_DATA_W{1'b1}});
      send_beat(CMD_UNPROJECT, pack_req(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 32'h1_0000));
      send_beat(CMD_UNPROJECT, pack_req(32'h0, 32'h0, 32'h0, 16'h7FFF, 16'h8000, 32'hFFFF_FFFF));
      send_beat(CMD_UNPROJECT, pack_req(32'h0, 32'h0, 32'h0, 16'h8000, 16'h7FFF, 32'h0));
      send_beat(CMD_UNPROJECT, pack_req(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 32'hFFFF_FFFF));
      send_beat(CMD_UNPROJECT, pack_req(32'h0, 32'h0, 32'h0, 16'h0005, 16'hFFFB, 32'h8000_0000));
      send_beat(CMD_UNPROJECT, {REQ_DATA_W{1'b1}});
      drain();

      // random beats, one camera set-up per phase
      for (phase = 1; phase < PHASES; phase++) begin
         load_camera(phase);
         for (int n = 0; n < PHASE_BEATS; n++) begin
            sender_busy = (n % 64) < 16;
            send_random();
         end
         drain();
      end
      sender_busy = 1'b0;
      for (int n = 0; n < 120; n++) send_random();

      // let the last results out, then decide
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      $display("covered %0d projections and %0d unprojections, %0d with valid_res set,",
               n_project, n_unproject, n_good);
      $display("over %0d camera set-ups including extreme and zero focal lengths", PHASES);
      if (errors == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
